/* hdl/pooled_sorted_linked_list_defines.svh */
// Assertion helpers for the checker in psll_chk.sv.
`ifndef POOLED_SORTED_LINKED_LIST_DEFINES_SVH
`define POOLED_SORTED_LINKED_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSLL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psll check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PSLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psll check failed");

`endif

/* hdl/psll_pkg.sv */
package psll_pkg;

	localparam int IDW  = 6;
	localparam int KW   = 64;
	localparam int CNTW = 7;
	localparam int STW  = 2;
	localparam int RTW  = 4;

	localparam logic [RTW-1:0] REQ_INS_BEFORE  = 4'd0;
	localparam logic [RTW-1:0] REQ_INS_AFTER   = 4'd1;
	localparam logic [RTW-1:0] REQ_FREE        = 4'd2;
	localparam logic [RTW-1:0] REQ_MOVE_BEFORE = 4'd3;
	localparam logic [RTW-1:0] REQ_MOVE_AFTER  = 4'd4;
	localparam logic [RTW-1:0] REQ_UPDATE_KEY  = 4'd5;
	localparam logic [RTW-1:0] REQ_PUSH_FRONT  = 4'd6;
	localparam logic [RTW-1:0] REQ_PUSH_BACK   = 4'd7;
	localparam logic [RTW-1:0] REQ_POP_FRONT   = 4'd8;
	localparam logic [RTW-1:0] REQ_POP_BACK    = 4'd9;
	localparam logic [RTW-1:0] REQ_PEEK_FRONT  = 4'd10;
	localparam logic [RTW-1:0] REQ_PEEK_BACK   = 4'd11;

	localparam logic [STW-1:0] ST_OK     = 2'd0;
	localparam logic [STW-1:0] ST_FULL   = 2'd1;
	localparam logic [STW-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STW-1:0] ST_NOT_IN = 2'd3;

	typedef enum logic [2:0] {
		CLS_INS,
		CLS_FREE,
		CLS_MOVE,
		CLS_UPD,
		CLS_TAKE,
		CLS_NOP
	} cls_t;

	// where a link operation finds its reference node
	typedef enum logic [1:0] {
		SEL_REF,
		SEL_HEAD,
		SEL_TAIL
	} sel_t;

	typedef struct packed {
		cls_t           cls;
		sel_t           sel;
		logic           after;
		logic           need_ref;
		logic           use_key;
		logic           remove;
		logic           at_tail;
		logic [IDW-1:0] ref_node;
		logic [IDW-1:0] src_node;
		logic [KW-1:0]  key;
	} cmd_t;

endpackage

/* hdl/psll_req_if.sv */
interface psll_req_if #(parameter int DATA_WIDTH = 32);
	logic                       valid;
	logic                       ready;
	logic [psll_pkg::RTW-1:0]   req_type;
	logic [psll_pkg::IDW-1:0]   ref_node;
	logic                       ref_is_null;
	logic [psll_pkg::IDW-1:0]   src_node;
	logic [psll_pkg::KW-1:0]    key_in;
	logic [DATA_WIDTH-1:0]      data_in;

	modport source (output valid, req_type, ref_node, ref_is_null, src_node, key_in, data_in,
		input ready);
	modport sink (input valid, req_type, ref_node, ref_is_null, src_node, key_in, data_in,
		output ready);
endinterface

/* hdl/psll_rsp_if.sv */
interface psll_rsp_if #(parameter int DATA_WIDTH = 32);
	logic                       valid;
	logic                       ready;
	logic [psll_pkg::IDW-1:0]   node_out;
	logic [DATA_WIDTH-1:0]      data_out;
	logic [psll_pkg::STW-1:0]   status;
	logic [psll_pkg::CNTW-1:0]  count_out;

	modport source (output valid, node_out, data_out, status, count_out, input ready);
	modport sink (input valid, node_out, data_out, status, count_out, output ready);
endinterface

/* hdl/psll_ram.sv */
module psll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/psll_front.sv */
module psll_front #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	psll_req_if.sink               req,
	output psll_pkg::cmd_t         cmd,
	output logic [DATA_WIDTH-1:0]  cmd_data,
	output logic                   cmd_valid,
	input  logic                   cmd_pop
);
	psll_pkg::cmd_t        cls_c;
	psll_pkg::cmd_t        cmd_q [2];
	logic [DATA_WIDTH-1:0] dat_q [2];
	logic                  wp_q, rp_q;
	logic [1:0]            cnt_q;
	logic                  push;

	always_comb begin
		cls_c          = '0;
		cls_c.cls      = psll_pkg::CLS_NOP;
		cls_c.sel      = psll_pkg::SEL_REF;
		cls_c.ref_node = req.ref_node;
		cls_c.src_node = req.src_node;
		cls_c.key      = req.key_in;
		unique case (req.req_type)
			psll_pkg::REQ_INS_BEFORE: begin
				cls_c.cls     = psll_pkg::CLS_INS;
				cls_c.use_key = 1'b1;
				if (req.ref_is_null) begin
					cls_c.sel   = psll_pkg::SEL_TAIL;
					cls_c.after = 1'b1;
				end else begin
					cls_c.need_ref = 1'b1;
				end
			end
			psll_pkg::REQ_INS_AFTER: begin
				cls_c.cls     = psll_pkg::CLS_INS;
				cls_c.use_key = 1'b1;
				if (req.ref_is_null) begin
					cls_c.sel = psll_pkg::SEL_HEAD;
				end else begin
					cls_c.need_ref = 1'b1;
					cls_c.after    = 1'b1;
				end
			end
			psll_pkg::REQ_FREE:        cls_c.cls = psll_pkg::CLS_FREE;
			psll_pkg::REQ_MOVE_BEFORE: cls_c.cls = psll_pkg::CLS_MOVE;
			psll_pkg::REQ_MOVE_AFTER: begin
				cls_c.cls   = psll_pkg::CLS_MOVE;
				cls_c.after = 1'b1;
			end
			psll_pkg::REQ_UPDATE_KEY:  cls_c.cls = psll_pkg::CLS_UPD;
			psll_pkg::REQ_PUSH_FRONT: begin
				cls_c.cls = psll_pkg::CLS_INS;
				cls_c.sel = psll_pkg::SEL_HEAD;
			end
			psll_pkg::REQ_PUSH_BACK: begin
				cls_c.cls   = psll_pkg::CLS_INS;
				cls_c.sel   = psll_pkg::SEL_TAIL;
				cls_c.after = 1'b1;
			end
			psll_pkg::REQ_POP_FRONT: begin
				cls_c.cls    = psll_pkg::CLS_TAKE;
				cls_c.remove = 1'b1;
			end
			psll_pkg::REQ_POP_BACK: begin
				cls_c.cls     = psll_pkg::CLS_TAKE;
				cls_c.remove  = 1'b1;
				cls_c.at_tail = 1'b1;
			end
			psll_pkg::REQ_PEEK_FRONT:  cls_c.cls = psll_pkg::CLS_TAKE;
			psll_pkg::REQ_PEEK_BACK: begin
				cls_c.cls     = psll_pkg::CLS_TAKE;
				cls_c.at_tail = 1'b1;
			end
			default: cls_c.cls = psll_pkg::CLS_NOP;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmd_q[rp_q];
	assign cmd_data  = dat_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q] <= cls_c;
			dat_q[wp_q] <= req.data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

/* hdl/psll_back.sv */
module psll_back #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psll_pkg::cmd_t        cmd,
	input  logic [DATA_WIDTH-1:0] cmd_data,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	psll_rsp_if.source            rsp
);
	localparam int IW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam int XW = (LW > psll_pkg::IDW) ? LW : psll_pkg::IDW;
	localparam int KW = psll_pkg::KW;
	localparam logic [LW-1:0] NIL = LW'(NODES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_AGET = 4'd1;
	localparam logic [3:0] S_AWR  = 4'd2;
	localparam logic [3:0] S_LRD  = 4'd3;
	localparam logic [3:0] S_LW1  = 4'd4;
	localparam logic [3:0] S_LW2  = 4'd5;
	localparam logic [3:0] S_URD  = 4'd6;
	localparam logic [3:0] S_UW   = 4'd7;
	localparam logic [3:0] S_REL  = 4'd8;
	localparam logic [3:0] S_KGET = 4'd9;
	localparam logic [3:0] S_WRD  = 4'd10;
	localparam logic [3:0] S_WEV  = 4'd11;
	localparam logic [3:0] S_WEND = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	logic [3:0]              st_q;
	psll_pkg::cmd_t          cmd_q;
	logic [DATA_WIDTH-1:0]   dat_q;
	logic [LW-1:0]           n_q, lk_r_q, nb_q, p_q;
	logic [LW-1:0]           head_q, tail_q, count_q, fresh_q, fsp_q;
	logic [NODES-1:0]        in_list_q;
	psll_pkg::sel_t          lk_sel_q;
	logic                    lk_after_q, rel_q, phase_q;
	logic [DATA_WIDTH-1:0]   dn_q;
	logic [psll_pkg::STW-1:0] res_q;

	logic                    out_valid_q;
	logic [psll_pkg::IDW-1:0] out_node_q;
	logic [DATA_WIDTH-1:0]   out_data_q;
	logic [psll_pkg::STW-1:0] out_st_q;
	logic [psll_pkg::CNTW-1:0] out_cnt_q;

	// memory ports
	logic                  key_we, dat_we, nxt_we, prv_we, stk_we;
	logic [IW-1:0]         key_wa, dat_wa, nxt_wa, prv_wa, stk_wa;
	logic [IW-1:0]         key_ra, dat_ra, lnk_ra, stk_ra;
	logic [KW-1:0]         key_wd, key_rd;
	logic [DATA_WIDTH-1:0] dat_wd, dat_rd;
	logic [LW-1:0]         nxt_wd, nxt_rd, prv_wd, prv_rd;
	logic [IW-1:0]         stk_wd, stk_rd;

	logic [XW-1:0] ref_x, src_x;
	logic          memb_ref, memb_src, full, take_go;
	logic [LW-1:0] ref_l, src_l, take_n, r_eff, nb_c;
	logic          tie;

	assign ref_x    = XW'(cmd.ref_node);
	assign src_x    = XW'(cmd.src_node);
	assign ref_l    = LW'(ref_x);
	assign src_l    = LW'(src_x);
	assign memb_ref = (ref_x < XW'(NODES)) && in_list_q[ref_x[IW-1:0]];
	assign memb_src = (src_x < XW'(NODES)) && in_list_q[src_x[IW-1:0]];
	assign full     = (fsp_q == '0) && (fresh_q == NIL);
	assign take_n   = cmd.at_tail ? tail_q : head_q;
	assign take_go  = (st_q == S_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_pop  = take_go;

	always_comb begin
		unique case (lk_sel_q)
			psll_pkg::SEL_HEAD: r_eff = head_q;
			psll_pkg::SEL_TAIL: r_eff = tail_q;
			default:            r_eff = lk_r_q;
		endcase
	end

	assign nb_c = lk_after_q ? nxt_rd : prv_rd;
	assign tie  = (key_rd == cmd_q.key) && (dat_rd < dn_q);

	// read addresses
	assign stk_ra = IW'(fsp_q - LW'(1));
	always_comb begin
		key_ra = p_q[IW-1:0];
		dat_ra = p_q[IW-1:0];
		lnk_ra = p_q[IW-1:0];
		unique case (st_q)
			S_IDLE: begin
				key_ra = ref_x[IW-1:0];
				dat_ra = ref_x[IW-1:0];
			end
			S_LRD: lnk_ra = r_eff[IW-1:0];
			S_URD: lnk_ra = n_q[IW-1:0];
			S_FIN: dat_ra = n_q[IW-1:0];
			default: ;
		endcase
	end

	// write ports
	always_comb begin
		key_we = 1'b0; key_wa = n_q[IW-1:0]; key_wd = '0;
		dat_we = 1'b0; dat_wa = n_q[IW-1:0]; dat_wd = dat_q;
		nxt_we = 1'b0; nxt_wa = n_q[IW-1:0]; nxt_wd = NIL;
		prv_we = 1'b0; prv_wa = n_q[IW-1:0]; prv_wd = NIL;
		stk_we = 1'b0; stk_wa = fsp_q[IW-1:0]; stk_wd = n_q[IW-1:0];
		unique case (st_q)
			S_IDLE: begin
				// move zeroes the key of the moved node
				if (take_go && cmd.cls == psll_pkg::CLS_MOVE && memb_ref && memb_src) begin
					key_we = 1'b1;
					key_wa = src_x[IW-1:0];
				end
			end
			S_AWR: begin
				key_we = 1'b1;
				key_wd = cmd_q.use_key ? cmd_q.key : '0;
				dat_we = 1'b1;
			end
			S_LRD: begin
				if (r_eff == NIL) begin
					nxt_we = 1'b1;
					prv_we = 1'b1;
				end
			end
			S_LW1: begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
				nxt_wd = lk_after_q ? nb_c : lk_r_q;
				prv_wd = lk_after_q ? lk_r_q : nb_c;
			end
			S_LW2: begin
				if (lk_after_q) begin
					nxt_we = 1'b1;
					nxt_wa = lk_r_q[IW-1:0];
					nxt_wd = n_q;
					prv_we = (nb_q != NIL);
					prv_wa = nb_q[IW-1:0];
					prv_wd = n_q;
				end else begin
					prv_we = 1'b1;
					prv_wa = lk_r_q[IW-1:0];
					prv_wd = n_q;
					nxt_we = (nb_q != NIL);
					nxt_wa = nb_q[IW-1:0];
					nxt_wd = n_q;
				end
			end
			S_UW: begin
				nxt_we = (prv_rd != NIL);
				nxt_wa = prv_rd[IW-1:0];
				nxt_wd = nxt_rd;
				prv_we = (nxt_rd != NIL);
				prv_wa = nxt_rd[IW-1:0];
				prv_wd = prv_rd;
			end
			S_REL: stk_we = 1'b1;
			S_WEND: begin
				key_we = 1'b1;
				key_wd = cmd_q.key;
			end
			default: ;
		endcase
	end

	psll_ram #(.WIDTH(KW), .DEPTH(NODES)) u_key (
		.clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
	psll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_dat (
		.clk(clk), .we(dat_we), .waddr(dat_wa), .wdata(dat_wd), .raddr(dat_ra), .rdata(dat_rd));
	psll_ram #(.WIDTH(LW), .DEPTH(NODES)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(lnk_ra), .rdata(nxt_rd));
	psll_ram #(.WIDTH(LW), .DEPTH(NODES)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(lnk_ra), .rdata(prv_rd));
	psll_ram #(.WIDTH(IW), .DEPTH(NODES)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

	always_ff @(posedge clk) begin
		if (take_go) begin
			cmd_q  <= cmd;
			dat_q  <= cmd_data;
			lk_r_q <= ref_l;
		end else if (st_q == S_LRD) begin
			lk_r_q <= r_eff;
		end else if (st_q == S_WEND) begin
			lk_r_q <= p_q;
		end
		if (st_q == S_LW1) begin
			nb_q <= nb_c;
		end
		if (st_q == S_KGET) begin
			dn_q <= dat_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			n_q         <= NIL;
			p_q         <= NIL;
			res_q       <= psll_pkg::ST_OK;
			head_q      <= NIL;
			tail_q      <= NIL;
			count_q     <= '0;
			fresh_q     <= '0;
			fsp_q       <= '0;
			in_list_q   <= '0;
			lk_sel_q    <= psll_pkg::SEL_REF;
			lk_after_q  <= 1'b0;
			rel_q       <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_node_q  <= '0;
			out_data_q  <= '0;
			out_st_q    <= psll_pkg::ST_OK;
			out_cnt_q   <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (take_go) begin
						res_q      <= psll_pkg::ST_OK;
						n_q        <= NIL;
						lk_sel_q   <= cmd.sel;
						lk_after_q <= cmd.after;
						st_q       <= S_FIN;
						unique case (cmd.cls)
							psll_pkg::CLS_INS: begin
								if (cmd.need_ref && !memb_ref) begin
									res_q <= psll_pkg::ST_NOT_IN;
								end else if (full) begin
									res_q <= psll_pkg::ST_FULL;
								end else if (fsp_q != '0) begin
									st_q <= S_AGET;
								end else begin
									n_q     <= fresh_q;
									fresh_q <= fresh_q + LW'(1);
									st_q    <= S_AWR;
								end
							end
							psll_pkg::CLS_FREE: begin
								if (!memb_ref) begin
									res_q <= psll_pkg::ST_NOT_IN;
								end else begin
									n_q   <= ref_l;
									rel_q <= 1'b1;
									st_q  <= S_URD;
								end
							end
							psll_pkg::CLS_MOVE: begin
								if (!memb_ref || !memb_src) begin
									res_q <= psll_pkg::ST_NOT_IN;
								end else begin
									n_q   <= src_l;
									rel_q <= 1'b0;
									if (src_l != ref_l) begin
										st_q <= S_URD;
									end
								end
							end
							psll_pkg::CLS_UPD: begin
								if (!memb_ref) begin
									res_q <= psll_pkg::ST_NOT_IN;
								end else begin
									n_q  <= ref_l;
									st_q <= S_KGET;
								end
							end
							psll_pkg::CLS_TAKE: begin
								if (take_n == NIL) begin
									res_q <= psll_pkg::ST_EMPTY;
								end else begin
									n_q   <= take_n;
									rel_q <= 1'b1;
									if (cmd.remove) begin
										st_q <= S_URD;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_AGET: begin
					n_q   <= LW'(stk_rd);
					fsp_q <= fsp_q - LW'(1);
					st_q  <= S_AWR;
				end
				S_AWR: begin
					in_list_q[n_q[IW-1:0]] <= 1'b1;
					count_q <= count_q + LW'(1);
					st_q    <= S_LRD;
				end
				S_LRD: begin
					if (r_eff == NIL) begin
						head_q <= n_q;
						tail_q <= n_q;
						st_q   <= S_FIN;
					end else begin
						st_q <= S_LW1;
					end
				end
				S_LW1: st_q <= S_LW2;
				S_LW2: begin
					if (nb_q == NIL) begin
						if (lk_after_q) begin
							tail_q <= n_q;
						end else begin
							head_q <= n_q;
						end
					end
					st_q <= S_FIN;
				end
				S_URD: st_q <= S_UW;
				S_UW: begin
					if (prv_rd == NIL) begin
						head_q <= nxt_rd;
					end
					if (nxt_rd == NIL) begin
						tail_q <= prv_rd;
					end
					st_q <= rel_q ? S_REL : S_LRD;
				end
				S_REL: begin
					in_list_q[n_q[IW-1:0]] <= 1'b0;
					fsp_q   <= fsp_q + LW'(1);
					count_q <= count_q - LW'(1);
					st_q    <= S_FIN;
				end
				S_KGET: begin
					// a key that does not grow searches from the head
					p_q     <= (cmd_q.key <= key_rd) ? head_q : n_q;
					phase_q <= 1'b0;
					st_q    <= S_WRD;
				end
				S_WRD: st_q <= (p_q == NIL) ? S_WEND : S_WEV;
				S_WEV: begin
					if (!phase_q && key_rd < cmd_q.key) begin
						p_q  <= nxt_rd;
						st_q <= S_WRD;
					end else if (tie) begin
						phase_q <= 1'b1;
						p_q     <= nxt_rd;
						st_q    <= S_WRD;
					end else begin
						st_q <= S_WEND;
					end
				end
				S_WEND: begin
					rel_q <= 1'b0;
					if (p_q == n_q) begin
						st_q <= S_FIN;
					end else begin
						lk_sel_q   <= (p_q == NIL) ? psll_pkg::SEL_TAIL : psll_pkg::SEL_REF;
						lk_after_q <= (p_q == NIL);
						st_q       <= S_URD;
					end
				end
				S_FIN: st_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					out_node_q  <= (n_q == NIL) ? '0 : psll_pkg::IDW'(n_q);
					out_data_q  <= (n_q == NIL) ? '0 : dat_rd;
					out_st_q    <= res_q;
					out_cnt_q   <= psll_pkg::CNTW'(count_q);
					st_q        <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.node_out  = out_node_q;
	assign rsp.data_out  = out_data_q;
	assign rsp.status    = out_st_q;
	assign rsp.count_out = out_cnt_q;
endmodule

/* hdl/pooled_sorted_linked_list.sv */
// Key update walks the list node by node, one read at a time through the single read
// port of each node RAM. One request is worked at a time, the next starts after the
// result transfer; a 2-entry queue keeps accepting meanwhile. Reset (arst_n low)
// empties list and pool at once.
module pooled_sorted_linked_list #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	psll_req_if.sink   req,
	psll_rsp_if.source rsp
);
	psll_pkg::cmd_t        cmd;
	logic [DATA_WIDTH-1:0] cmd_data;
	logic                  cmd_valid, cmd_pop;

	psll_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cmd(cmd), .cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop));

	psll_back #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.rsp(rsp));
endmodule

/* hdl/psll_chk.sv */
`include "pooled_sorted_linked_list_defines.svh"

module psll_chk #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [psll_pkg::IDW-1:0]   node_out,
	input logic [DATA_WIDTH-1:0]      data_out,
	input logic [psll_pkg::STW-1:0]   status,
	input logic [psll_pkg::CNTW-1:0]  count_out
);
	`PSLL_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid)
	`PSLL_ASSERT_NEXT(a_stable, rsp_valid && !rsp_ready, $stable({node_out, data_out, status, count_out}))
	`PSLL_ASSERT_NOW(a_fail_zero, rsp_valid && status != psll_pkg::ST_OK, node_out == '0 && data_out == '0)
	`PSLL_ASSERT_NOW(a_empty, rsp_valid && status == psll_pkg::ST_EMPTY, count_out == '0)
	`PSLL_ASSERT_NOW(a_full, rsp_valid && status == psll_pkg::ST_FULL, count_out == psll_pkg::CNTW'(NODES))
endmodule

bind pooled_sorted_linked_list psll_chk #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.node_out(rsp.node_out), .data_out(rsp.data_out), .status(rsp.status),
	.count_out(rsp.count_out));

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int NODES      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int NIL        = NODES;
	localparam int RAND_ITEMS = 400;
	localparam int CALM_ITEMS = 60;
	localparam int CYCLE_LIMIT = 600000;

	localparam logic [psll_pkg::RTW-1:0] REQ_UNUSED_LO = 4'd12;
	localparam logic [psll_pkg::RTW-1:0] REQ_UNUSED_HI = 4'd15;

	typedef struct {
		logic [psll_pkg::RTW-1:0] req_type;
		logic [psll_pkg::IDW-1:0] ref_node;
		logic                     ref_is_null;
		logic [psll_pkg::IDW-1:0] src_node;
		logic [psll_pkg::KW-1:0]  key;
		logic [DATA_WIDTH-1:0]    data;
	} request_t;

	typedef struct {
		logic [psll_pkg::IDW-1:0]  node;
		logic [DATA_WIDTH-1:0]     data;
		logic [psll_pkg::STW-1:0]  status;
		logic [psll_pkg::CNTW-1:0] count;
	} answer_t;

	typedef struct {
		request_t rq;
		logic     typed;
		answer_t  ans;
	} row_t;

	logic clk;
	logic arst_n;
	logic quiet;
	logic failed;
	int   cycles;
	int   op_seen [16];
	int   full_seen;
	int   answers_checked;

	psll_req_if #(.DATA_WIDTH(DATA_WIDTH)) req ();
	psll_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp ();

	pooled_sorted_linked_list #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// list image kept alongside the block
	logic [psll_pkg::KW-1:0] lst_key  [NODES];
	logic [DATA_WIDTH-1:0]   lst_data [NODES];
	int                      lst_next [NODES];
	int                      lst_prev [NODES];
	logic                    lst_in   [NODES];
	int                      lst_head, lst_tail, free_head, lst_count;

	answer_t pending_answers [$];

	function automatic void list_clear();
		for (int i = 0; i < NODES; i++) begin
			lst_key[i]  = '0;
			lst_data[i] = '0;
			lst_next[i] = i + 1;
			lst_prev[i] = NIL;
			lst_in[i]   = 1'b0;
		end
		lst_head  = NIL;
		lst_tail  = NIL;
		free_head = 0;
		lst_count = 0;
	endfunction

	function automatic bit is_member(int n);
		return n < NIL && lst_in[n];
	endfunction

	function automatic void unlink(int n);
		int p;
		int x;
		p = lst_prev[n];
		x = lst_next[n];
		if (p != NIL) lst_next[p] = x; else lst_head = x;
		if (x != NIL) lst_prev[x] = p; else lst_tail = p;
		lst_next[n] = NIL;
		lst_prev[n] = NIL;
	endfunction

	function automatic void link_before(int n, int r);
		int p;
		p = lst_prev[r];
		lst_next[n] = r;
		lst_prev[n] = p;
		lst_prev[r] = n;
		if (p != NIL) lst_next[p] = n; else lst_head = n;
	endfunction

	function automatic void link_after(int n, int r);
		int x;
		x = lst_next[r];
		lst_prev[n] = r;
		lst_next[n] = x;
		lst_next[r] = n;
		if (x != NIL) lst_prev[x] = n; else lst_tail = n;
	endfunction

	function automatic void link_front(int n);
		if (lst_head == NIL) begin
			lst_next[n] = NIL;
			lst_prev[n] = NIL;
			lst_head = n;
			lst_tail = n;
		end else begin
			link_before(n, lst_head);
		end
	endfunction

	function automatic void link_back(int n);
		if (lst_tail == NIL) link_front(n);
		else link_after(n, lst_tail);
	endfunction

	function automatic void release_node(int n);
		unlink(n);
		lst_key[n]  = '0;
		lst_in[n]   = 1'b0;
		lst_next[n] = free_head;
		free_head   = n;
		lst_count--;
	endfunction

	function automatic void rekey(int n, logic [psll_pkg::KW-1:0] k);
		int p;
		p = (k <= lst_key[n]) ? lst_head : n;
		while (p != NIL && lst_key[p] < k) p = lst_next[p];
		while (p != NIL && lst_key[p] == k && lst_data[p] < lst_data[n]) p = lst_next[p];
		if (p != n) begin
			unlink(n);
			if (p == NIL) link_back(n);
			else link_before(n, p);
		end
		lst_key[n] = k;
	endfunction

	// apply one request to the list image and return the answer it gives
	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int      node;
		int      rf;
		int      sr;
		int      n;
		logic [psll_pkg::STW-1:0] st;
		node = NIL;
		st   = psll_pkg::ST_OK;
		rf   = r.ref_node;
		sr   = r.src_node;
		case (r.req_type)
			psll_pkg::REQ_INS_BEFORE, psll_pkg::REQ_INS_AFTER, psll_pkg::REQ_PUSH_FRONT,
			psll_pkg::REQ_PUSH_BACK: begin
				if ((r.req_type == psll_pkg::REQ_INS_BEFORE
						|| r.req_type == psll_pkg::REQ_INS_AFTER)
						&& !r.ref_is_null && !is_member(rf)) begin
					st = psll_pkg::ST_NOT_IN;
				end else if (free_head >= NIL) begin
					st = psll_pkg::ST_FULL;
				end else begin
					n = free_head;
					free_head = lst_next[n];
					lst_key[n] = (r.req_type == psll_pkg::REQ_PUSH_FRONT
						|| r.req_type == psll_pkg::REQ_PUSH_BACK) ? '0 : r.key;
					lst_data[n] = r.data;
					lst_in[n] = 1'b1;
					lst_count++;
					node = n;
					if (r.req_type == psll_pkg::REQ_PUSH_FRONT) link_front(n);
					else if (r.req_type == psll_pkg::REQ_PUSH_BACK) link_back(n);
					else if (r.ref_is_null) begin
						if (r.req_type == psll_pkg::REQ_INS_BEFORE) link_back(n);
						else link_front(n);
					end else if (r.req_type == psll_pkg::REQ_INS_BEFORE) link_before(n, rf);
					else link_after(n, rf);
				end
			end
			psll_pkg::REQ_FREE: begin
				if (!is_member(rf)) st = psll_pkg::ST_NOT_IN;
				else begin
					node = rf;
					release_node(rf);
				end
			end
			psll_pkg::REQ_MOVE_BEFORE, psll_pkg::REQ_MOVE_AFTER: begin
				if (!is_member(rf) || !is_member(sr)) st = psll_pkg::ST_NOT_IN;
				else begin
					node = sr;
					lst_key[sr] = '0;
					if (sr != rf) begin
						unlink(sr);
						if (r.req_type == psll_pkg::REQ_MOVE_BEFORE) link_before(sr, rf);
						else link_after(sr, rf);
					end
				end
			end
			psll_pkg::REQ_UPDATE_KEY: begin
				if (!is_member(rf)) st = psll_pkg::ST_NOT_IN;
				else begin
					node = rf;
					rekey(rf, r.key);
				end
			end
			psll_pkg::REQ_POP_FRONT, psll_pkg::REQ_POP_BACK, psll_pkg::REQ_PEEK_FRONT,
			psll_pkg::REQ_PEEK_BACK: begin
				n = (r.req_type == psll_pkg::REQ_POP_FRONT
					|| r.req_type == psll_pkg::REQ_PEEK_FRONT) ? lst_head : lst_tail;
				if (n >= NIL) st = psll_pkg::ST_EMPTY;
				else begin
					node = n;
					if (r.req_type == psll_pkg::REQ_POP_FRONT
							|| r.req_type == psll_pkg::REQ_POP_BACK)
						release_node(n);
				end
			end
			default: ;
		endcase
		if (node < NIL) begin
			a.node = node[psll_pkg::IDW-1:0];
			a.data = lst_data[node];
		end else begin
			a.node = '0;
			a.data = '0;
		end
		a.status = st;
		a.count  = lst_count[psll_pkg::CNTW-1:0];
		return a;
	endfunction

	function automatic row_t mk(logic [psll_pkg::RTW-1:0] t, int rf, logic nl, int sr,
			logic [psll_pkg::KW-1:0] k, logic [DATA_WIDTH-1:0] d, logic typed,
			int en, logic [DATA_WIDTH-1:0] ed, logic [psll_pkg::STW-1:0] es, int ec);
		row_t w;
		w.rq.req_type    = t;
		w.rq.ref_node    = rf[psll_pkg::IDW-1:0];
		w.rq.ref_is_null = nl;
		w.rq.src_node    = sr[psll_pkg::IDW-1:0];
		w.rq.key         = k;
		w.rq.data        = d;
		w.typed          = typed;
		w.ans.node       = en[psll_pkg::IDW-1:0];
		w.ans.data       = ed;
		w.ans.status     = es;
		w.ans.count      = ec[psll_pkg::CNTW-1:0];
		return w;
	endfunction

	// pick a list member most of the time, any index otherwise
	function automatic int pick_node();
		int p;
		int steps;
		if (lst_count == 0 || $urandom_range(0, 19) == 0) return $urandom_range(0, NODES - 1);
		p = lst_head;
		steps = $urandom_range(0, lst_count - 1);
		repeat (steps) p = lst_next[p];
		return p;
	endfunction

	function automatic request_t random_request(int bias);
		request_t r;
		int w;
		r.ref_node    = psll_pkg::IDW'(pick_node());
		r.src_node    = psll_pkg::IDW'(pick_node());
		r.ref_is_null = ($urandom_range(0, 4) == 0);
		r.data        = $urandom;
		case ($urandom_range(0, 3))
			0:       r.key = {$urandom, $urandom};
			1:       r.key = {2{32'hFFFF_FFFF}};
			default: r.key = 64'($urandom_range(0, 7));
		endcase
		w = $urandom_range(0, 99);
		if (w < bias) begin
			case ($urandom_range(0, 3))
				0: r.req_type = psll_pkg::REQ_INS_BEFORE;
				1: r.req_type = psll_pkg::REQ_INS_AFTER;
				2: r.req_type = psll_pkg::REQ_PUSH_FRONT;
				default: r.req_type = psll_pkg::REQ_PUSH_BACK;
			endcase
		end else if (w >= 97) begin
			r.req_type = psll_pkg::RTW'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
		end else begin
			case ($urandom_range(0, 7))
				0: r.req_type = psll_pkg::REQ_FREE;
				1: r.req_type = psll_pkg::REQ_MOVE_BEFORE;
				2: r.req_type = psll_pkg::REQ_MOVE_AFTER;
				3: r.req_type = psll_pkg::REQ_UPDATE_KEY;
				4: r.req_type = psll_pkg::REQ_POP_FRONT;
				5: r.req_type = psll_pkg::REQ_POP_BACK;
				6: r.req_type = psll_pkg::REQ_PEEK_FRONT;
				default: r.req_type = psll_pkg::REQ_PEEK_BACK;
			endcase
		end
		return r;
	endfunction

	task automatic send(request_t r, logic typed, answer_t typed_ans);
		answer_t a;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.req_type    <= r.req_type;
		req.ref_node    <= r.ref_node;
		req.ref_is_null <= r.ref_is_null;
		req.src_node    <= r.src_node;
		req.key_in      <= r.key;
		req.data_in     <= r.data;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		a = apply_request(r);
		op_seen[r.req_type]++;
		if (a.status == psll_pkg::ST_FULL) full_seen++;
		pending_answers.push_back(typed ? typed_ans : a);
	endtask

	// response side stalls in random bursts
	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected transfer node=%0d data=%h status=%0d count=%0d",
					$realtime, rsp.node_out, rsp.data_out, rsp.status, rsp.count_out);
				failed = 1'b1;
			end else begin
				e = pending_answers.pop_front();
				answers_checked++;
				if (rsp.node_out !== e.node || rsp.data_out !== e.data
						|| rsp.status !== e.status || rsp.count_out !== e.count) begin
					$display("%0t: mismatch expected node=%0d data=%h status=%0d count=%0d",
						$realtime, e.node, e.data, e.status, e.count);
					$display("%0t:          actual   node=%0d data=%h status=%0d count=%0d",
						$realtime, rsp.node_out, rsp.data_out, rsp.status, rsp.count_out);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d transfers still outstanding", $realtime,
				pending_answers.size());
			$display("** pooled_sorted_linked_list: FAILED **");
			$finish;
		end
	end

	initial begin
		row_t     rows [$];
		request_t r;
		answer_t  none;
		int       bias;
		failed          = 1'b0;
		quiet           = 1'b0;
		cycles          = 0;
		full_seen       = 0;
		answers_checked = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
		none = '{default: '0};
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.req_type    = '0;
		req.ref_node    = '0;
		req.ref_is_null = 1'b0;
		req.src_node    = '0;
		req.key_in      = '0;
		req.data_in     = '0;
		list_clear();

		rows.push_back(mk(psll_pkg::REQ_PEEK_FRONT, 0, 0, 0, 0, 0, 1, 0, 0,
			psll_pkg::ST_EMPTY, 0));
		rows.push_back(mk(psll_pkg::REQ_POP_BACK, 0, 0, 0, 0, 0, 1, 0, 0,
			psll_pkg::ST_EMPTY, 0));
		rows.push_back(mk(psll_pkg::REQ_FREE, 5, 0, 0, 0, 0, 1, 0, 0,
			psll_pkg::ST_NOT_IN, 0));
		rows.push_back(mk(psll_pkg::REQ_INS_BEFORE, 3, 0, 0, 0, 0, 1, 0, 0,
			psll_pkg::ST_NOT_IN, 0));
		rows.push_back(mk(psll_pkg::REQ_INS_BEFORE, 63, 1, 0, '1, '1, 1, 0, '1,
			psll_pkg::ST_OK, 1));
		rows.push_back(mk(psll_pkg::REQ_INS_AFTER, 0, 1, 0, 0, 0, 1, 1, 0,
			psll_pkg::ST_OK, 2));
		rows.push_back(mk(psll_pkg::REQ_PUSH_FRONT, 0, 0, 0, 9, 32'h1234_5678, 1, 2,
			32'h1234_5678, psll_pkg::ST_OK, 3));
		rows.push_back(mk(psll_pkg::REQ_PUSH_BACK, 0, 0, 0, 9, 32'hA5A5_A5A5, 1, 3,
			32'hA5A5_A5A5, psll_pkg::ST_OK, 4));
		rows.push_back(mk(psll_pkg::REQ_INS_AFTER, 0, 0, 0, 5, 7, 1, 4, 7,
			psll_pkg::ST_OK, 5));
		rows.push_back(mk(psll_pkg::REQ_INS_BEFORE, 3, 0, 0, 5, 3, 1, 5, 3,
			psll_pkg::ST_OK, 6));
		rows.push_back(mk(psll_pkg::REQ_MOVE_BEFORE, 0, 0, 3, 0, 0, 1, 3, 32'hA5A5_A5A5,
			psll_pkg::ST_OK, 6));
		rows.push_back(mk(psll_pkg::REQ_MOVE_AFTER, 4, 0, 4, 0, 0, 1, 4, 7,
			psll_pkg::ST_OK, 6));
		rows.push_back(mk(psll_pkg::REQ_MOVE_BEFORE, 0, 0, 63, 0, 0, 1, 0, 0,
			psll_pkg::ST_NOT_IN, 6));
		rows.push_back(mk(psll_pkg::REQ_UPDATE_KEY, 0, 0, 0, 5, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_UPDATE_KEY, 2, 0, 0, 0, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_UPDATE_KEY, 5, 0, 0, '1, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_UPDATE_KEY, 4, 0, 0, 5, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_PEEK_FRONT, 0, 0, 0, 0, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_PEEK_BACK, 0, 0, 0, 0, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_POP_FRONT, 0, 0, 0, 0, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_POP_BACK, 0, 0, 0, 0, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(psll_pkg::REQ_FREE, 4, 0, 0, 0, 0, 0, 0, 0,
			psll_pkg::ST_OK, 0));
		rows.push_back(mk(REQ_UNUSED_LO, 7, 1, 9, '1, '1, 0, 0, 0, psll_pkg::ST_OK, 0));
		rows.push_back(mk(REQ_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0, 0, psll_pkg::ST_OK, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send(rows[i].rq, rows[i].typed, rows[i].ans);

		// alternate filling and draining so the pool runs full and empty
		for (int i = 0; i < RAND_ITEMS; i++) begin
			case (i / 100)
				0: bias = 85;
				1: bias = 25;
				2: bias = 80;
				default: bias = 35;
			endcase
			if (i >= RAND_ITEMS - CALM_ITEMS) quiet = 1'b1;
			r = random_request(bias);
			send(r, 1'b0, none);
		end
		req.valid <= 1'b0;

		while (pending_answers.size() != 0) @(posedge clk);
		repeat (2 * NODES + 40) @(posedge clk);

		$display("covered %0d requests: ins %0d/%0d free %0d move %0d/%0d update %0d",
			answers_checked, op_seen[psll_pkg::REQ_INS_BEFORE],
			op_seen[psll_pkg::REQ_INS_AFTER], op_seen[psll_pkg::REQ_FREE],
			op_seen[psll_pkg::REQ_MOVE_BEFORE], op_seen[psll_pkg::REQ_MOVE_AFTER],
			op_seen[psll_pkg::REQ_UPDATE_KEY]);
		$display("push %0d/%0d pop %0d/%0d peek %0d/%0d, pool full hit %0d times",
			op_seen[psll_pkg::REQ_PUSH_FRONT], op_seen[psll_pkg::REQ_PUSH_BACK],
			op_seen[psll_pkg::REQ_POP_FRONT], op_seen[psll_pkg::REQ_POP_BACK],
			op_seen[psll_pkg::REQ_PEEK_FRONT], op_seen[psll_pkg::REQ_PEEK_BACK],
			full_seen);
		if (!failed) begin
			$display("** pooled_sorted_linked_list: PASSED **");
		end else begin
			$display("** pooled_sorted_linked_list: FAILED **");
		end
		$finish;
	end

endmodule
